/* hw/rtl/rlbn_pkg.sv */
// ----------------------------------------------------------------------------
// rlbn_pkg
// Shared constants and types for the depth-limited neighborhood search block:
// store sizes, field widths, operation codes and controller states.
// ----------------------------------------------------------------------------
package rlbn_pkg;

  // store sizes
  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;

  // field widths; the address and count widths derive from the store sizes
  localparam int VW  = 6;                          // vertex id field width
  localparam int EAW = $clog2(MAX_EDGES);          // edge memory address
  localparam int ECW = $clog2(MAX_EDGES + 1);      // edge count
  localparam int DAW = $clog2(MAX_VERTICES);       // discovery list address
  localparam int DCW = $clog2(MAX_VERTICES + 1);   // discovery count
  localparam int RW  = 8;                          // radius field width

  // operation codes carried on the input tuser
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_FETCH,
    ST_CUR,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_WR
  } st_t;

endpackage

/* hw/rtl/radius_limited_bfs_neighbourhood.sv */
// ----------------------------------------------------------------------------
// radius_limited_bfs_neighbourhood
// Directed edge store with level-by-level, direction-blind neighborhood
// queries around a center vertex.
// ----------------------------------------------------------------------------
// Adds (tuser 0), clears (tuser 2) and the unused code 3 may arrive back to
// back while the output is free; each gives one word on the output. A query
// (tuser 1) holds the input off while it runs: the edge memory has one read
// port, so every frontier vertex costs two full passes over the stored edges.
// The answer then goes out one vertex at a time as the output takes it. It
// lists the discovered vertices in discovery order, the center first, with
// tlast on the final word.
module radius_limited_bfs_neighbourhood
  import rlbn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // from_vertex, to_vertex, center, radius, zero fill
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // vertex, zero fill
  output logic        m_tlast,
  output logic [0:0]  m_tuser    // status
);

  // input fields
  logic [VW-1:0] in_from;
  logic [VW-1:0] in_to;
  logic [VW-1:0] in_center;
  logic [RW-1:0] in_radius;
  op_t           in_op;

  assign in_from   = s_tdata[VW-1:0];
  assign in_to     = s_tdata[2*VW-1:VW];
  assign in_center = s_tdata[3*VW-1:2*VW];
  assign in_radius = s_tdata[3*VW+RW-1:3*VW];
  assign in_op     = op_t'(s_tuser);

  // memories
  logic [2*VW-1:0] edge_mem [MAX_EDGES];   // {target, source}
  logic [VW-1:0]   list_mem [MAX_VERTICES];
  logic [2*VW-1:0] edge_rd;
  logic [VW-1:0]   list_rd;

  // control and datapath registers
  st_t              state;
  st_t              state_next;
  logic [ECW-1:0]   edge_count;
  logic [MAX_VERTICES-1:0] visited;
  logic [DCW-1:0]   dcount;
  logic [DCW-1:0]   lvl_start;
  logic [DCW-1:0]   lvl_end;
  logic [DCW-1:0]   idx;
  logic [DAW-1:0]   out_idx;
  logic [RW-1:0]    level;
  logic [RW-1:0]    radius;
  logic [VW-1:0]    cur;
  logic             pass;
  logic [ECW-1:0]   eaddr;
  logic             pend;
  logic [VW-1:0]    out_vertex;
  logic             out_last;
  logic             out_status;

  // control decode
  logic             accept;
  logic             out_free;
  logic             out_load;
  logic             edge_re;
  logic             list_re;
  logic [DAW-1:0]   list_raddr;
  logic             scan_issue;
  logic             scan_done;
  logic             frontier_done;

  // scan compare on the word that came back from the edge memory
  logic [VW-1:0]    e_src;
  logic [VW-1:0]    e_tgt;
  logic [VW-1:0]    e_key;
  logic [VW-1:0]    e_other;
  logic             hit;

  assign out_free      = !m_tvalid || m_tready;
  assign accept        = s_tvalid && s_tready;
  assign out_load      = (state == ST_IDLE && accept && in_op != OP_QUERY) ||
                         (state == ST_EMIT_WR && out_free);
  assign scan_issue    = (eaddr != edge_count);
  assign scan_done     = !scan_issue && !pend;
  assign frontier_done = (idx == lvl_end);

  assign e_src   = edge_rd[VW-1:0];
  assign e_tgt   = edge_rd[2*VW-1:VW];
  assign e_key   = pass ? e_src : e_tgt;
  assign e_other = pass ? e_tgt : e_src;
  assign hit     = pend && (e_key == cur) && !visited[e_other] &&
                   (dcount != DCW'(MAX_VERTICES));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && in_op == OP_QUERY) begin
          state_next = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        if (level >= radius) begin
          state_next = ST_EMIT_RD;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (!frontier_done) begin
          state_next = ST_CUR;
        end else if (dcount == lvl_end) begin
          state_next = ST_EMIT_RD;
        end else begin
          state_next = ST_LEVEL;
        end
      end
      ST_CUR: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done && pass) begin
          state_next = ST_FETCH;
        end
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (out_free) begin
          if ((DCW'(out_idx) + DCW'(1)) == dcount) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    s_tready   = 1'b0;
    edge_re    = 1'b0;
    list_re    = 1'b0;
    list_raddr = idx[DAW-1:0];
    case (state)
      ST_IDLE: begin
        s_tready = out_free;
      end
      ST_FETCH: begin
        list_re = !frontier_done;
      end
      ST_SCAN: begin
        edge_re = scan_issue;
      end
      ST_EMIT_RD: begin
        list_re    = 1'b1;
        list_raddr = out_idx;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // edge memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && in_op == OP_ADD &&
        edge_count != ECW'(MAX_EDGES)) begin
      edge_mem[edge_count[EAW-1:0]] <= {in_to, in_from};
    end
    if (edge_re) begin
      edge_rd <= edge_mem[eaddr[EAW-1:0]];
    end
  end

  // discovery list memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && in_op == OP_QUERY) begin
      list_mem[0] <= in_center;
    end else if (state == ST_SCAN && hit) begin
      list_mem[dcount[DAW-1:0]] <= e_other;
    end
    if (list_re) begin
      list_rd <= list_mem[list_raddr];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
      visited    <= '0;
      dcount     <= '0;
      lvl_start  <= '0;
      lvl_end    <= '0;
      idx        <= '0;
      out_idx    <= '0;
      level      <= '0;
      radius     <= '0;
      pass       <= 1'b0;
      eaddr      <= '0;
      pend       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // output word loaded or taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_op)
              OP_ADD: begin
                if (edge_count != ECW'(MAX_EDGES)) begin
                  edge_count <= edge_count + ECW'(1);
                end
              end
              OP_QUERY: begin
                visited   <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << in_center;
                dcount    <= DCW'(1);
                lvl_start <= '0;
                lvl_end   <= DCW'(1);
                level     <= RW'(1);
                radius    <= in_radius;
                out_idx   <= '0;
              end
              OP_CLEAR: begin
                edge_count <= '0;
              end
              default: begin
                pend <= 1'b0;
              end
            endcase
          end
        end
        ST_LEVEL: begin
          idx <= lvl_start;
        end
        ST_FETCH: begin
          // end of a level that found new vertices opens the next one
          if (frontier_done && dcount != lvl_end) begin
            lvl_start <= lvl_end;
            lvl_end   <= dcount;
            level     <= level + RW'(1);
          end
        end
        ST_CUR: begin
          pass  <= 1'b0;
          eaddr <= '0;
          pend  <= 1'b0;
        end
        ST_SCAN: begin
          // issue one edge read per cycle, compare the word from the cycle before
          pend <= scan_issue;
          if (scan_issue) begin
            eaddr <= eaddr + ECW'(1);
          end
          if (hit) begin
            visited[e_other] <= 1'b1;
            dcount           <= dcount + DCW'(1);
          end
          // in-edges done, then out-edges done
          if (scan_done) begin
            if (!pass) begin
              pass  <= 1'b1;
              eaddr <= '0;
            end else begin
              idx <= idx + DCW'(1);
            end
          end
        end
        ST_EMIT_WR: begin
          if (out_free) begin
            out_idx <= out_idx + DAW'(1);
          end
        end
        default: begin
          pend <= 1'b0;
        end
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      out_vertex <= '0;
      out_last   <= 1'b1;
      out_status <= (in_op == OP_ADD) && (edge_count == ECW'(MAX_EDGES));
    end else if (state == ST_EMIT_WR && out_free) begin
      out_vertex <= list_rd;
      out_last   <= (DCW'(out_idx) + DCW'(1)) == dcount;
      out_status <= 1'b0;
    end
  end

  // current frontier vertex
  always_ff @(posedge clk) begin
    if (state == ST_CUR) begin
      cur <= list_rd;
    end
  end

  assign m_tdata = {{(8 - VW){1'b0}}, out_vertex};
  assign m_tlast = out_last;
  assign m_tuser = out_status;

endmodule

/* tb/radius_limited_bfs_neighbourhood_tb.sv */
// ----------------------------------------------------------------------------
// radius_limited_bfs_neighbourhood_tb
// Self-checking bench for the edge store and neighborhood search block. An
// internal model of the edge list predicts every output word of each accepted
// input word: add status, clear and no-op acks, and the vertex list of a
// query in discovery order. The stimulus is a short directed part, then
// sessions of clear, adds and queries on small or full vertex pools. One
// session is a 64-vertex chain and one fills the store past capacity. The
// sender works in random bursts and the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module radius_limited_bfs_neighbourhood_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rlbn_pkg::*;

  localparam int RUN_LIMIT    = 2_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 340;

  // one output word as predicted
  typedef struct packed {
    logic [VW-1:0] vertex;
    logic          last;
    logic          status;
  } answer_t;

  // edge list model and queue of expected output words
  class neighbourhood_checker;
    logic [VW-1:0] edge_src [MAX_EDGES];
    logic [VW-1:0] edge_dst [MAX_EDGES];
    int            edge_total;
    answer_t       answers [$];
    bit            seen [MAX_VERTICES];
    logic [VW-1:0] order [MAX_VERTICES];
    int            found;
    int            errors, words_checked, adds, drops, queries, others, widest;

    function new();
      edge_total    = 0;
      errors        = 0;
      words_checked = 0;
      adds          = 0;
      drops         = 0;
      queries       = 0;
      others        = 0;
      widest        = 0;
    endfunction

    function int pending();
      return answers.size();
    endfunction

    function void push_answer(logic [VW-1:0] v, logic last, logic status);
      answer_t a;
      a.vertex = v;
      a.last   = last;
      a.status = status;
      answers = {answers, a};
    endfunction

    // append a vertex to the discovery order if not yet reached
    function void visit(logic [VW-1:0] v);
      if (!seen[v]) begin
        seen[v]      = 1'b1;
        order[found] = v;
        found++;
      end
    endfunction

    // accepted input word: update the edge list, queue its answer
    function void note_input(op_t op, logic [31:0] d);
      logic [VW-1:0] from_v, to_v, centre;
      logic [RW-1:0] radius;
      int            lvl_lo, lvl_hi, lvl, i, e;
      from_v = d[5:0];
      to_v   = d[11:6];
      centre = d[17:12];
      radius = d[25:18];
      case (op)
        OP_ADD: begin
          adds++;
          if (edge_total >= MAX_EDGES) begin
            drops++;
            push_answer('0, 1'b1, 1'b1);
          end else begin
            edge_src[edge_total] = from_v;
            edge_dst[edge_total] = to_v;
            edge_total++;
            push_answer('0, 1'b1, 1'b0);
          end
        end
        OP_QUERY: begin
          queries++;
          for (i = 0; i < MAX_VERTICES; i++) seen[i] = 1'b0;
          found = 0;
          visit(centre);
          lvl_lo = 0;
          lvl_hi = found;
          // level by level; in-edges give sources, out-edges give targets
          for (lvl = 1; lvl < int'(radius); lvl++) begin
            for (i = lvl_lo; i < lvl_hi; i++) begin
              for (e = 0; e < edge_total; e++)
                if (edge_dst[e] == order[i]) visit(edge_src[e]);
              for (e = 0; e < edge_total; e++)
                if (edge_src[e] == order[i]) visit(edge_dst[e]);
            end
            if (found == lvl_hi) break;
            lvl_lo = lvl_hi;
            lvl_hi = found;
          end
          if (found > widest) widest = found;
          for (i = 0; i < found; i++) push_answer(order[i], i == found - 1, 1'b0);
        end
        default: begin
          others++;
          if (op == OP_CLEAR) edge_total = 0;
          push_answer('0, 1'b1, 1'b0);
        end
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH word %0d: %s", words_checked, msg);
      errors++;
    endtask

    // accepted output word against the oldest expectation
    task check_result(logic [VW-1:0] v, logic last, logic status);
      answer_t a;
      words_checked++;
      if (answers.size() == 0) begin
        report($sformatf("unexpected word vertex=%0d last=%0b status=%0b", v, last, status));
        return;
      end
      a = answers.pop_front();
      if (v !== a.vertex)
        report($sformatf("vertex got %0d want %0d", v, a.vertex));
      if (last !== a.last)
        report($sformatf("last got %0b want %0b", last, a.last));
      if (status !== a.status)
        report($sformatf("status got %0b want %0b", status, a.status));
    endtask
  endclass

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = OP_NONE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [0:0]  m_tuser;

  neighbourhood_checker sb = new();

  int cycle_count = 0;
  int stall_left  = 0;
  int stall_mode  = 0;
  int burst_left;
  bit tx_live     = 1'b0;
  int rand_items  = 0;
  int pool_base, pool_span;

  radius_limited_bfs_neighbourhood dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // monitor both handshakes and drive the receiver stall pattern
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(op_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata[VW-1:0], m_tlast, m_tuser[0]);
    end
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      2: m_tready <= (cycle_count[1:0] == 2'd0);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // run guard
  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("run stopped at cycle limit %0d", cycle_count);
    $display("FAIL radius_limited_bfs_neighbourhood");
    $finish;
  end

  function automatic logic [31:0] pack_word(logic [VW-1:0] f, logic [VW-1:0] t,
                                            logic [VW-1:0] c, logic [RW-1:0] r);
    return {6'b0, r, c, t, f};
  endfunction

  // one input word; the sender drops valid between bursts
  task automatic send_word(op_t op, logic [31:0] d);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= d;
    tx_live = 1'b1;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      tx_live = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic add_edge(logic [VW-1:0] f, logic [VW-1:0] t);
    send_word(OP_ADD, pack_word(f, t, VW'($urandom), RW'($urandom)));
  endtask

  task automatic query(logic [VW-1:0] c, logic [RW-1:0] r);
    send_word(OP_QUERY, pack_word(VW'($urandom), VW'($urandom), c, r));
  endtask

  task automatic clear_store();
    send_word(OP_CLEAR, $urandom & 32'h03ff_ffff);
  endtask

  // hold the sender until every expected word has arrived
  task automatic wait_idle();
    if (tx_live) begin
      s_tvalid <= 1'b0;
      tx_live = 1'b0;
    end
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [VW-1:0] pick_vertex();
    return VW'(pool_base + $urandom_range(0, pool_span - 1));
  endfunction

  function automatic logic [VW-1:0] pick_centre();
    return ($urandom_range(0, 9) < 7) ? pick_vertex() : VW'($urandom_range(0, 63));
  endfunction

  // mostly short radii, sometimes unlimited or fully random
  function automatic logic [RW-1:0] pick_radius();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return RW'($urandom_range(0, 6));
    if (r < 7) return 8'd255;
    return RW'($urandom_range(0, 255));
  endfunction

  // clear, then adds mixed with queries and the odd noise word
  task automatic normal_session();
    int n_edges, k, r;
    pool_base = $urandom_range(0, 63);
    pool_span = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(2, 12);
    clear_store();
    rand_items++;
    n_edges = $urandom_range(1, 30);
    k = 0;
    while (k < n_edges) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        add_edge(pick_vertex(), pick_vertex());
        k++;
      end else if (r < 9) begin
        query(pick_centre(), pick_radius());
      end else if ($urandom_range(0, 2) == 0) begin
        clear_store();
      end else begin
        send_word(OP_NONE, $urandom & 32'h03ff_ffff);
      end
      rand_items++;
    end
    repeat ($urandom_range(2, 4)) begin
      query(pick_centre(), pick_radius());
      rand_items++;
    end
  endtask

  // all 64 vertices on one path of random edge directions
  task automatic chain_session();
    int perm [64];
    int i, j, t;
    for (i = 0; i < 64; i++) perm[i] = i;
    for (i = 63; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    clear_store();
    for (i = 0; i < 63; i++) begin
      if ($urandom_range(0, 1)) add_edge(VW'(perm[i]), VW'(perm[i + 1]));
      else add_edge(VW'(perm[i + 1]), VW'(perm[i]));
    end
    query(VW'(perm[0]), 8'd64);
    query(VW'(perm[0]), 8'd63);
    query(VW'(perm[$urandom_range(0, 63)]), 8'd255);
    query(VW'(perm[$urandom_range(0, 63)]), pick_radius());
    rand_items += 68;
  endtask

  // fill the store past capacity on a tiny pool
  task automatic fill_session();
    int i;
    clear_store();
    for (i = 0; i < MAX_EDGES + 3; i++)
      add_edge(VW'($urandom_range(0, 7)), VW'($urandom_range(0, 7)));
    query(VW'($urandom_range(0, 7)), 8'd255);
    query(VW'($urandom_range(0, 7)), 8'd2);
    clear_store();
    add_edge(6'd7, 6'd0);
    query(6'd0, 8'd255);
    rand_items += MAX_EDGES + 9;
  endtask

  initial begin
    int session;
    burst_left = $urandom_range(1, 12);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty store, no-op code, extreme ids, radius edges, clear
    query(6'd63, 8'd0);
    send_word(OP_NONE, 32'h03ff_ffff);
    add_edge(6'd0, 6'd63);
    add_edge(6'd63, 6'd5);
    add_edge(6'd5, 6'd5);
    add_edge(6'd63, 6'd0);
    add_edge(6'd1, 6'd63);
    query(6'd63, 8'd0);
    query(6'd63, 8'd1);
    query(6'd63, 8'd2);
    query(6'd63, 8'd255);
    query(6'd5, 8'd3);
    query(6'd42, 8'd255);
    clear_store();
    query(6'd0, 8'd255);
    add_edge(6'd63, 6'd63);
    query(6'd63, 8'd2);
    send_word(OP_CLEAR, 32'h03ff_ffff);
    wait_idle();

    // random sessions
    session = 0;
    while (rand_items < RANDOM_WORDS) begin
      if (session == 0) chain_session();
      else if (session == 1) fill_session();
      else normal_session();
      if (session == 1 || $urandom_range(0, 5) == 0) wait_idle();
      session++;
    end

    // drain and settle
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d words never arrived", sb.pending()));

    $display("covered %0d adds (%0d dropped on a full store), %0d queries, %0d clears/no-ops",
             sb.adds, sb.drops, sb.queries, sb.others);
    $display("checked %0d output words, widest answer %0d vertices, %0d mismatches",
             sb.words_checked, sb.widest, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS radius_limited_bfs_neighbourhood");
    end else begin
      $display("FAIL radius_limited_bfs_neighbourhood");
    end
    $finish;
  end

endmodule
